// ===== sv/point_light_diffuse_shade_top_defines.svh =====
// assertion macros for the shader rtl (used by the queue)
`ifndef POINT_LIGHT_DIFFUSE_SHADE_TOP_DEFINES_SVH
`define POINT_LIGHT_DIFFUSE_SHADE_TOP_DEFINES_SVH

// condition holds at every clock edge out of reset
`define PLDS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define PLDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/plds_pkg.sv =====
// shared types and constants for the point light diffuse shader
package plds_pkg;

    localparam int COLOR_BITS  = 8;
    localparam int CMAX        = (1 << COLOR_BITS) - 1;
    localparam int POS_W       = 32;
    localparam int NRM_W       = 16;
    localparam int DIF_W       = 33;
    localparam int NORM_BITS   = 20;
    localparam int BITS_W      = 6;
    localparam int SHIFT_W     = 4;
    localparam int C_W         = NORM_BITS + 1;
    localparam int SQ_W        = 2 * NORM_BITS;
    localparam int PR_W        = C_W + NRM_W - 1;
    localparam int DOT_W       = PR_W + 2;
    localparam int SUM_W       = SQ_W + 2;
    localparam int ROOT_W      = 31;
    localparam int REM_W       = 64;
    localparam int DIV_BITS    = 10;
    localparam int F_W         = 10;
    localparam int F_MAX       = 1023;
    localparam int NUM_W       = 48;
    localparam int DVS_W       = ROOT_W + 5;
    localparam int FLOOR_W     = 8;
    localparam int X_W         = COLOR_BITS + 11;
    localparam int RECIP_W     = X_W - 8;
    localparam longint unsigned RECIP = (64'd1 << X_W) / 64'd510;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DAT_W   = 32;
    localparam int AMBIENT_RESET = 51;

    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y       = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Z       = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AMBIENT_FLOOR = 8'd3;

    typedef logic [COLOR_BITS-1:0] t_color;

    typedef struct packed {
        t_color red;
        t_color green;
        t_color blue;
    } t_rgb;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_light;

    // normalized light vector plus what the back end needs
    typedef struct packed {
        logic signed [C_W-1:0]   cx;
        logic signed [C_W-1:0]   cy;
        logic signed [C_W-1:0]   cz;
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
        logic signed [NRM_W-1:0] nz;
        t_rgb                    col;
    } t_vec;

endpackage

// ===== sv/plds_ifs.sv =====
// valid/ready channel interfaces of the shader
interface plds_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [plds_pkg::POS_W-1:0]    pos_x;
    logic signed [plds_pkg::POS_W-1:0]    pos_y;
    logic signed [plds_pkg::POS_W-1:0]    pos_z;
    logic signed [plds_pkg::NRM_W-1:0]    normal_x;
    logic signed [plds_pkg::NRM_W-1:0]    normal_y;
    logic signed [plds_pkg::NRM_W-1:0]    normal_z;
    plds_pkg::t_color                     texel_red;
    plds_pkg::t_color                     texel_green;
    plds_pkg::t_color                     texel_blue;
    modport source (output valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                    texel_red, texel_green, texel_blue, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                    texel_red, texel_green, texel_blue, output ready);
endinterface

interface plds_out_if;
    logic             valid;
    logic             ready;
    plds_pkg::t_color shade_red;
    plds_pkg::t_color shade_green;
    plds_pkg::t_color shade_blue;
    modport source (output valid, shade_red, shade_green, shade_blue, input ready);
    modport sink   (input valid, shade_red, shade_green, shade_blue, output ready);
endinterface

interface plds_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [plds_pkg::CFG_IDX_W-1:0]     addr;
    logic [plds_pkg::CFG_DAT_W-1:0]     data;
    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// ===== sv/plds_front.sv =====
// front end: accepts pixels, forms and normalizes the light vector
module plds_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    plds_in_if.sink          i_pix,
    input  plds_pkg::t_light i_light,
    input  logic             i_take,
    output logic             o_valid,
    output plds_pkg::t_vec   o_vec
);
    logic                                r_valid;
    plds_pkg::t_vec                      r_vec;
    plds_pkg::t_vec                      n_vec;
    logic signed [plds_pkg::DIF_W-1:0]   dif [3];
    logic [plds_pkg::DIF_W-1:0]          mag [3];
    logic [plds_pkg::DIF_W-1:0]          m;
    logic [plds_pkg::BITS_W-1:0]         bits;
    logic [plds_pkg::SHIFT_W-1:0]        k;
    logic [plds_pkg::DIF_W-1:0]          sm [3];
    logic signed [plds_pkg::C_W-1:0]     c [3];
    logic                                accept;

    assign accept      = i_pix.valid && i_pix.ready;
    assign i_pix.ready = !r_valid || i_take;

    always_comb begin
        dif[0] = plds_pkg::DIF_W'(i_light.x) - plds_pkg::DIF_W'(i_pix.pos_x);
        dif[1] = plds_pkg::DIF_W'(i_light.y) - plds_pkg::DIF_W'(i_pix.pos_y);
        dif[2] = plds_pkg::DIF_W'(i_light.z) - plds_pkg::DIF_W'(i_pix.pos_z);
        for (int a = 0; a < 3; a++) begin
            mag[a] = dif[a][plds_pkg::DIF_W-1] ? -dif[a] : dif[a];
        end
        m = mag[0];
        if (mag[1] > m) m = mag[1];
        if (mag[2] > m) m = mag[2];
        // bit length of the largest magnitude
        bits = '0;
        for (int b = 0; b < plds_pkg::DIF_W; b++) begin
            if (m[b]) bits = plds_pkg::BITS_W'(b + 1);
        end
        k = (bits > plds_pkg::BITS_W'(plds_pkg::NORM_BITS))
            ? plds_pkg::SHIFT_W'(bits - plds_pkg::BITS_W'(plds_pkg::NORM_BITS)) : '0;
        for (int a = 0; a < 3; a++) begin
            sm[a] = mag[a] >> k;
            c[a]  = dif[a][plds_pkg::DIF_W-1]
                    ? -$signed({1'b0, sm[a][plds_pkg::NORM_BITS-1:0]})
                    : $signed({1'b0, sm[a][plds_pkg::NORM_BITS-1:0]});
        end
        n_vec.cx        = c[0];
        n_vec.cy        = c[1];
        n_vec.cz        = c[2];
        n_vec.nx        = i_pix.normal_x;
        n_vec.ny        = i_pix.normal_y;
        n_vec.nz        = i_pix.normal_z;
        n_vec.col.red   = i_pix.texel_red;
        n_vec.col.green = i_pix.texel_green;
        n_vec.col.blue  = i_pix.texel_blue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_vec <= n_vec;
        end
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;
endmodule

// ===== sv/plds_queue.sv =====
// short queue between front and back end
`include "point_light_diffuse_shade_top_defines.svh"
module plds_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  plds_pkg::t_vec i_entry,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output plds_pkg::t_vec o_entry
);
    plds_pkg::t_vec                r_mem [plds_pkg::QUEUE_DEPTH];
    logic [plds_pkg::QPTR_W-1:0]   r_wr;
    logic [plds_pkg::QPTR_W-1:0]   r_rd;
    logic [plds_pkg::QCNT_W-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    assign o_full  = (r_count == plds_pkg::QCNT_W'(plds_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd];

    `PLDS_ASSERT_ALWAYS(a_count_max, r_count <= plds_pkg::QCNT_W'(plds_pkg::QUEUE_DEPTH), "queue count past depth")
    `PLDS_ASSERT_ALWAYS(a_no_underflow, !(i_pop && o_empty), "pop from empty queue")
    `PLDS_ASSERT_NEXT(a_push_count, i_push && !i_pop, r_count == plds_pkg::QCNT_W'($past(r_count) + 1'b1), "push lost")
endmodule

// ===== sv/plds_back.sv =====
// back end: length, dot product, factor division and channel scaling
module plds_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  plds_pkg::t_vec                i_vec,
    output logic                          o_pop,
    input  logic [plds_pkg::FLOOR_W-1:0]  i_floor,
    plds_out_if.source                    o_shade
);
    localparam int RW = plds_pkg::ROOT_W;
    localparam int DB = plds_pkg::DIV_BITS;

    logic en;

    // products
    logic                                r_a_valid;
    logic [plds_pkg::SQ_W-1:0]           r_a_sq [3];
    logic signed [plds_pkg::PR_W-1:0]    r_a_pr [3];
    plds_pkg::t_rgb                      r_a_col;

    // square root, one result bit per stage
    logic                                r_rt_valid [RW+1];
    logic [plds_pkg::REM_W-1:0]          r_rt_rem   [RW+1];
    logic [RW-1:0]                       r_rt_root  [RW+1];
    logic signed [plds_pkg::DOT_W-1:0]   r_rt_dot   [RW+1];
    plds_pkg::t_rgb                      r_rt_col   [RW+1];
    logic [plds_pkg::REM_W-1:0]          n_inc      [RW];

    // factor division, one quotient bit per stage
    logic                                r_dv_valid [DB+1];
    logic [plds_pkg::NUM_W-1:0]          r_dv_rem   [DB+1];
    logic [plds_pkg::DVS_W-1:0]          r_dv_div   [DB+1];
    logic [DB-1:0]                       r_dv_q     [DB+1];
    logic                                r_dv_zero  [DB+1];
    logic                                r_dv_sat   [DB+1];
    plds_pkg::t_rgb                      r_dv_col   [DB+1];
    logic [plds_pkg::NUM_W-1:0]          n_dsub     [DB];

    logic [plds_pkg::SUM_W-1:0]          n_sum;
    logic signed [plds_pkg::DOT_W-1:0]   n_dot;
    logic [RW-1:0]                       len;
    logic [plds_pkg::NUM_W-1:0]          n_num;
    logic [plds_pkg::DVS_W-1:0]          n_div;

    logic                                r_f_valid;
    logic [plds_pkg::F_W-1:0]            r_f;
    plds_pkg::t_rgb                      r_f_col;
    logic [plds_pkg::F_W-1:0]            n_f;

    logic                                r_x_valid;
    logic [plds_pkg::X_W-1:0]            r_x [3];
    logic                                r_p_valid;
    logic [plds_pkg::X_W-1:0]            r_p_x [3];
    logic [plds_pkg::RECIP_W-1:0]        r_p_q [3];
    logic                                r_o_valid;
    plds_pkg::t_color                    r_o [3];

    logic [plds_pkg::X_W+plds_pkg::RECIP_W-1:0] n_prod [3];
    logic [plds_pkg::X_W-1:0]            n_rem [3];
    logic [plds_pkg::RECIP_W-1:0]        n_q   [3];
    plds_pkg::t_color                    n_o   [3];
    plds_pkg::t_color                    f_col [3];
    logic signed [plds_pkg::C_W-1:0]     cv [3];
    logic signed [plds_pkg::NRM_W-1:0]   nv [3];

    assign en    = !r_o_valid || o_shade.ready;
    assign o_pop = en && !i_empty;

    always_comb begin
        cv[0] = i_vec.cx; cv[1] = i_vec.cy; cv[2] = i_vec.cz;
        nv[0] = i_vec.nx; nv[1] = i_vec.ny; nv[2] = i_vec.nz;
        n_sum = plds_pkg::SUM_W'(r_a_sq[0]) + plds_pkg::SUM_W'(r_a_sq[1])
              + plds_pkg::SUM_W'(r_a_sq[2]);
        n_dot = plds_pkg::DOT_W'(r_a_pr[0]) + plds_pkg::DOT_W'(r_a_pr[1])
              + plds_pkg::DOT_W'(r_a_pr[2]);
        for (int s = 0; s < RW; s++) begin
            n_inc[s] = (plds_pkg::REM_W'(r_rt_root[s]) << (RW - s))
                     + (plds_pkg::REM_W'(1) << (2 * (RW - 1 - s)));
        end
        len   = r_rt_root[RW];
        n_num = plds_pkg::NUM_W'(r_rt_dot[RW][plds_pkg::DOT_W-2:0]) * plds_pkg::NUM_W'(510)
              + (plds_pkg::NUM_W'(len) << 4);
        n_div = plds_pkg::DVS_W'(len) << 5;
        for (int j = 0; j < DB; j++) begin
            n_dsub[j] = plds_pkg::NUM_W'(r_dv_div[j]) << (DB - 1 - j);
        end
        // facing away or light at the point gives the floor
        if (r_dv_zero[DB]) begin
            n_f = '0;
        end else if (r_dv_sat[DB]) begin
            n_f = plds_pkg::F_W'(plds_pkg::F_MAX);
        end else begin
            n_f = r_dv_q[DB];
        end
        if (n_f < plds_pkg::F_W'(i_floor)) n_f = plds_pkg::F_W'(i_floor);
        f_col[0] = r_f_col.red; f_col[1] = r_f_col.green; f_col[2] = r_f_col.blue;
        for (int a = 0; a < 3; a++) begin
            n_prod[a] = (plds_pkg::X_W+plds_pkg::RECIP_W)'(r_x[a])
                      * (plds_pkg::X_W+plds_pkg::RECIP_W)'(plds_pkg::RECIP);
            n_rem[a]  = r_p_x[a] - plds_pkg::X_W'(r_p_q[a]) * plds_pkg::X_W'(510);
            n_q[a]    = (n_rem[a] >= plds_pkg::X_W'(510)) ? r_p_q[a] + 1'b1 : r_p_q[a];
            n_o[a]    = (n_q[a] > plds_pkg::RECIP_W'(plds_pkg::CMAX))
                      ? plds_pkg::t_color'(plds_pkg::CMAX) : n_q[a][plds_pkg::COLOR_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            for (int s = 0; s <= RW; s++) r_rt_valid[s] <= 1'b0;
            for (int j = 0; j <= DB; j++) r_dv_valid[j] <= 1'b0;
            r_f_valid <= 1'b0;
            r_x_valid <= 1'b0;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_a_valid     <= !i_empty;
            r_rt_valid[0] <= r_a_valid;
            for (int s = 0; s < RW; s++) r_rt_valid[s+1] <= r_rt_valid[s];
            r_dv_valid[0] <= r_rt_valid[RW];
            for (int j = 0; j < DB; j++) r_dv_valid[j+1] <= r_dv_valid[j];
            r_f_valid <= r_dv_valid[DB];
            r_x_valid <= r_f_valid;
            r_p_valid <= r_x_valid;
            r_o_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                r_a_sq[a] <= plds_pkg::SQ_W'(plds_pkg::SQ_W'(cv[a]) * plds_pkg::SQ_W'(cv[a]));
                r_a_pr[a] <= plds_pkg::PR_W'(cv[a]) * plds_pkg::PR_W'(nv[a]);
            end
            r_a_col <= i_vec.col;

            r_rt_rem[0]  <= plds_pkg::REM_W'(n_sum) << 20;
            r_rt_root[0] <= '0;
            r_rt_dot[0]  <= n_dot;
            r_rt_col[0]  <= r_a_col;
            for (int s = 0; s < RW; s++) begin
                if (r_rt_rem[s] >= n_inc[s]) begin
                    r_rt_rem[s+1]  <= r_rt_rem[s] - n_inc[s];
                    r_rt_root[s+1] <= r_rt_root[s] | (RW'(1) << (RW - 1 - s));
                end else begin
                    r_rt_rem[s+1]  <= r_rt_rem[s];
                    r_rt_root[s+1] <= r_rt_root[s];
                end
                r_rt_dot[s+1] <= r_rt_dot[s];
                r_rt_col[s+1] <= r_rt_col[s];
            end

            r_dv_rem[0]  <= n_num;
            r_dv_div[0]  <= n_div;
            r_dv_q[0]    <= '0;
            r_dv_zero[0] <= (r_rt_dot[RW] <= 0) || (len == '0);
            r_dv_sat[0]  <= n_num >= (plds_pkg::NUM_W'(n_div) << DB);
            r_dv_col[0]  <= r_rt_col[RW];
            for (int j = 0; j < DB; j++) begin
                if (r_dv_rem[j] >= n_dsub[j]) begin
                    r_dv_rem[j+1] <= r_dv_rem[j] - n_dsub[j];
                    r_dv_q[j+1]   <= r_dv_q[j] | (DB'(1) << (DB - 1 - j));
                end else begin
                    r_dv_rem[j+1] <= r_dv_rem[j];
                    r_dv_q[j+1]   <= r_dv_q[j];
                end
                r_dv_div[j+1]  <= r_dv_div[j];
                r_dv_zero[j+1] <= r_dv_zero[j];
                r_dv_sat[j+1]  <= r_dv_sat[j];
                r_dv_col[j+1]  <= r_dv_col[j];
            end

            r_f     <= n_f;
            r_f_col <= r_dv_col[DB];
            for (int a = 0; a < 3; a++) begin
                r_x[a]   <= plds_pkg::X_W'({f_col[a], 1'b0}) * plds_pkg::X_W'(r_f)
                          + plds_pkg::X_W'(255);
                r_p_x[a] <= r_x[a];
                r_p_q[a] <= n_prod[a][plds_pkg::X_W+plds_pkg::RECIP_W-1:plds_pkg::X_W];
                r_o[a]   <= n_o[a];
            end
        end
    end

    assign o_shade.valid       = r_o_valid;
    assign o_shade.shade_red   = r_o[0];
    assign o_shade.shade_green = r_o[1];
    assign o_shade.shade_blue  = r_o[2];
endmodule

// ===== sv/point_light_diffuse_shade_top.sv =====
// top level of the point light diffuse shader
//
//  channel   modport  direction  payload
//  i_pix     sink     in         pos_x/y/z, normal_x/y/z, texel_red/green/blue
//  o_shade   source   out        shade_red/green/blue
//  i_cfg     sink     in         addr, data (register writes, always ready)
//
// one pixel per clock sustained while o_shade is ready; the back pipeline depth is
// set mainly by the bit-per-stage square root (31 stages) and factor
// division (10 stages).
// synchronous active-low reset clears the valid bits, queue pointers and light, and sets the ambient floor to 51.
// a stalled output freezes the back pipeline; the queue and front register keep
// taking pixels until the queue fills.
module point_light_diffuse_shade_top (
    input  logic    i_clk,
    input  logic    i_rst_n,
    plds_in_if.sink     i_pix,
    plds_out_if.source  o_shade,
    plds_cfg_if.sink    i_cfg
);
    plds_pkg::t_light                 r_light;
    logic [plds_pkg::FLOOR_W-1:0]     r_floor;
    logic                             f_valid;
    plds_pkg::t_vec                   f_vec;
    plds_pkg::t_vec                   q_vec;
    logic                             q_full;
    logic                             q_empty;
    logic                             push;
    logic                             pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light <= '0;
            r_floor <= plds_pkg::FLOOR_W'(plds_pkg::AMBIENT_RESET);
        end else if (i_cfg.valid) begin
            case (i_cfg.addr)
                plds_pkg::REG_LIGHT_X:       r_light.x <= i_cfg.data;
                plds_pkg::REG_LIGHT_Y:       r_light.y <= i_cfg.data;
                plds_pkg::REG_LIGHT_Z:       r_light.z <= i_cfg.data;
                plds_pkg::REG_AMBIENT_FLOOR: r_floor   <= i_cfg.data[plds_pkg::FLOOR_W-1:0];
                default: ;
            endcase
        end
    end

    assign push = f_valid && !q_full;

    plds_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .i_light (r_light),
        .i_take  (push),
        .o_valid (f_valid),
        .o_vec   (f_vec)
    );

    plds_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (f_vec),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_entry (q_vec)
    );

    plds_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_vec   (q_vec),
        .o_pop   (pop),
        .i_floor (r_floor),
        .o_shade (o_shade)
    );
endmodule

// ===== test/plds_test_ifs.sv =====
// constants used by the testbench top
package plds_test_consts;
    localparam int LATENCY_GUARD = 200;
endpackage

// ===== test/plds_shade_checker.sv =====
// checker that predicts each lit pixel and compares it with the shader output
module plds_shade_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    plds_in_if         pix,
    plds_out_if        shade,
    plds_cfg_if        cfg,
    output int         o_fail_count,
    output int         o_pending
);
    logic signed [31:0] lit_x, lit_y, lit_z;
    logic [7:0]         amb_floor;
    plds_pkg::t_rgb     shade_q[$];

    function automatic longint unsigned root64(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint shrink_mag(longint v, int k);
        longint m;
        m = (v < 0 ? -v : v) >>> k;
        return v < 0 ? -m : m;
    endfunction

    function automatic plds_pkg::t_color lit_channel(plds_pkg::t_color t,
                                                     longint unsigned f);
        longint unsigned v;
        v = (2 * longint'(t) * f + 255) / 510;
        return v > plds_pkg::CMAX ? plds_pkg::t_color'(plds_pkg::CMAX) : plds_pkg::t_color'(v);
    endfunction

    function automatic plds_pkg::t_rgb predict_shade(logic signed [31:0] px,
                                                     logic signed [31:0] py,
                                                     logic signed [31:0] pz,
                                                     logic signed [15:0] nx,
                                                     logic signed [15:0] ny,
                                                     logic signed [15:0] nz,
                                                     plds_pkg::t_rgb tex);
        longint dx, dy, dz, dot;
        longint unsigned m, s, len, f;
        int nbits, k;
        plds_pkg::t_rgb res;
        dx = longint'(lit_x) - longint'(px);
        dy = longint'(lit_y) - longint'(py);
        dz = longint'(lit_z) - longint'(pz);
        m = dx < 0 ? -dx : dx;
        if ((dy < 0 ? -dy : dy) > m) m = dy < 0 ? -dy : dy;
        if ((dz < 0 ? -dz : dz) > m) m = dz < 0 ? -dz : dz;
        nbits = 0;
        while (nbits < 64 && (m >> nbits) != 0) nbits++;
        k = nbits > plds_pkg::NORM_BITS ? nbits - plds_pkg::NORM_BITS : 0;
        dx = shrink_mag(dx, k);
        dy = shrink_mag(dy, k);
        dz = shrink_mag(dz, k);
        s = dx * dx + dy * dy + dz * dz;
        len = root64(s << 20);
        dot = dx * longint'(nx) + dy * longint'(ny) + dz * longint'(nz);
        f = 0;
        if (dot > 0 && len != 0) begin
            f = (510 * longint'(dot) + 16 * len) / (32 * len);
            if (f > plds_pkg::F_MAX) f = plds_pkg::F_MAX;
        end
        if (f < amb_floor) f = amb_floor;
        res.red   = lit_channel(tex.red, f);
        res.green = lit_channel(tex.green, f);
        res.blue  = lit_channel(tex.blue, f);
        return res;
    endfunction

    assign o_pending = shade_q.size();

    always @(posedge i_clk) begin
        plds_pkg::t_rgb got, want, tex;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            lit_x <= '0;
            lit_y <= '0;
            lit_z <= '0;
            amb_floor <= 8'd51;
            o_fail_count <= 0;
            shade_q.delete();
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.addr)
                    plds_pkg::REG_LIGHT_X:       lit_x <= cfg.data;
                    plds_pkg::REG_LIGHT_Y:       lit_y <= cfg.data;
                    plds_pkg::REG_LIGHT_Z:       lit_z <= cfg.data;
                    plds_pkg::REG_AMBIENT_FLOOR: amb_floor <= cfg.data[7:0];
                    default: ;
                endcase
            end
            if (pix.valid && pix.ready) begin
                tex = {pix.texel_red, pix.texel_green, pix.texel_blue};
                shade_q.push_back(predict_shade(pix.pos_x, pix.pos_y, pix.pos_z,
                    pix.normal_x, pix.normal_y, pix.normal_z, tex));
            end
            if (shade.valid && shade.ready) begin
                got = {shade.shade_red, shade.shade_green, shade.shade_blue};
                if (shade_q.size() == 0) begin
                    $error("shade transaction with nothing expected");
                    errs++;
                end else begin
                    want = shade_q.pop_front();
                    if (got.red !== want.red) begin
                        $error("shade_red expected %0d actual %0d", want.red, got.red);
                        errs++;
                    end
                    if (got.green !== want.green) begin
                        $error("shade_green expected %0d actual %0d", want.green, got.green);
                        errs++;
                    end
                    if (got.blue !== want.blue) begin
                        $error("shade_blue expected %0d actual %0d", want.blue, got.blue);
                        errs++;
                    end
                end
            end
            if (errs != 0) o_fail_count <= o_fail_count + errs;
        end
    end
endmodule

// ===== test/point_light_diffuse_shade_top_test.sv =====
// testbench top: drives pixels and register writes, gives the verdict
module point_light_diffuse_shade_top_test;
    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;

    plds_in_if  pix ();
    plds_out_if shade ();
    plds_cfg_if cfg ();

    point_light_diffuse_shade_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_shade (shade),
        .i_cfg   (cfg)
    );

    plds_shade_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .pix          (pix),
        .shade        (shade),
        .cfg          (cfg),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // output side stalls at random, with a quiet stretch in the middle
    bit no_stall;
    initial begin
        int w;
        shade.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            w = no_stall ? 0 : $urandom_range(0, 5);
            if (w != 0) begin
                shade.ready <= 1'b0;
                repeat (w) @(negedge i_clk);
            end
            shade.ready <= 1'b1;
            @(posedge i_clk);
            while (!shade.valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    task automatic write_reg(logic [plds_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg.addr  <= idx;
        cfg.data  <= val;
        cfg.valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        pix.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (plds_test_consts::LATENCY_GUARD) @(negedge i_clk);
    endtask

    task automatic send_pixel(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                              logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                              logic [23:0] tex, bit gaps);
        int w;
        w = gaps ? $urandom_range(0, 5) : 0;
        if (w != 0) begin
            pix.valid <= 1'b0;
            repeat (w) @(negedge i_clk);
        end
        pix.pos_x <= px;
        pix.pos_y <= py;
        pix.pos_z <= pz;
        pix.normal_x <= nx;
        pix.normal_y <= ny;
        pix.normal_z <= nz;
        {pix.texel_red, pix.texel_green, pix.texel_blue} <= tex;
        pix.valid <= 1'b1;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_normal();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 32768)) - 16384);
            default: return 16'($signed($urandom_range(0, 2000)) - 1000 +
                                ($urandom_range(0, 1) ? 15000 : -15000));
        endcase
    endfunction

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
            2: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 9) :
                                             32'h80000000 + $urandom_range(0, 9);
            default: return 32'($signed($urandom_range(0, 200)) - 100);
        endcase
    endfunction

    initial begin
        logic [31:0] lx;
        pix.valid = 1'b0;
        pix.pos_x = '0;
        pix.pos_y = '0;
        pix.pos_z = '0;
        pix.normal_x = '0;
        pix.normal_y = '0;
        pix.normal_z = '0;
        pix.texel_red = '0;
        pix.texel_green = '0;
        pix.texel_blue = '0;
        cfg.valid = 1'b0;
        cfg.addr = '0;
        cfg.data = '0;
        no_stall = 1'b0;
        i_rst_n = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset config, light at point, facing away, long normals, extremes
        send_pixel(0, 0, 0, 16'd16384, 0, 0, 24'hffffff, 0);
        send_pixel(0, 0, 32'hffff0000, 0, 0, 16'd16384, 24'hff8000, 0);
        send_pixel(0, 0, 32'hffff0000, 0, 0, 16'hc000, 24'h80ff01, 1);
        send_pixel(0, 0, 32'hffff0000, 0, 0, 16'h7fff, 24'hffffff, 1);
        send_pixel(32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'h8000, 16'h8000, 16'h7fff,
                   24'hffffff, 1);
        send_pixel(32'h80000000, 32'h7fffffff, 32'h80000000, 16'h7fff, 16'h8000, 16'h8000,
                   24'h000000, 0);
        send_pixel(32'h00000001, 0, 0, 16'hc000, 0, 0, 24'h123456, 0);
        wait_drained();
        write_reg(plds_pkg::REG_LIGHT_X, 32'h7fffffff);
        write_reg(plds_pkg::REG_LIGHT_Y, 32'h80000000);
        write_reg(plds_pkg::REG_LIGHT_Z, 32'h00010000);
        write_reg(plds_pkg::REG_AMBIENT_FLOOR, 32'd0);
        write_reg(8'd200, 32'hffffffff);
        send_pixel(32'h80000000, 32'h7fffffff, 0, 16'd16384, 16'hc000, 0, 24'hffffff, 0);
        send_pixel(32'h7fffffff, 32'h80000000, 32'h00010000, 16'd16384, 0, 0, 24'hffffff, 0);
        send_pixel(32'h80000000, 32'h80000000, 0, 16'hc000, 0, 0, 24'hffffff, 1);
        send_pixel(32'h7fffffff, 32'h80000000, 0, 0, 0, 16'd16384, 24'h7f7f7f, 1);
        wait_drained();
        write_reg(plds_pkg::REG_AMBIENT_FLOOR, 32'd255);
        send_pixel(0, 0, 0, 16'hc000, 0, 0, 24'hffffff, 0);
        send_pixel(0, 0, 0, 16'h7fff, 16'h7fff, 16'h7fff, 24'h010101, 1);
        wait_drained();

        // random phases with fresh light and floor each time
        for (int ph = 0; ph < 10; ph++) begin
            lx = rand_pos();
            write_reg(plds_pkg::REG_LIGHT_X, lx);
            write_reg(plds_pkg::REG_LIGHT_Y, rand_pos());
            write_reg(plds_pkg::REG_LIGHT_Z, rand_pos());
            write_reg(plds_pkg::REG_AMBIENT_FLOOR,
                      ph == 0 ? 0 : ph == 1 ? 255 : $urandom_range(0, 255));
            no_stall = (ph == 4);
            for (int n = 0; n < 50; n++) begin
                logic [31:0] px;
                px = ($urandom_range(0, 15) == 0) ? lx : rand_pos();
                send_pixel(px, rand_pos(), rand_pos(), rand_normal(), rand_normal(),
                           rand_normal(), 24'($urandom), ph != 4);
            end
            // sender holds off here until every result has come back
            wait_drained();
        end
        no_stall = 1'b0;

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+sv
sv/plds_pkg.sv
sv/plds_ifs.sv
sv/plds_front.sv
sv/plds_queue.sv
sv/plds_back.sv
sv/point_light_diffuse_shade_top.sv
test/plds_test_ifs.sv
test/plds_shade_checker.sv
test/point_light_diffuse_shade_top_test.sv
